// File: rtl/scsm_pkg.sv
// Shared types and constants for the sensor calibration session monitor.
`default_nettype none

package scsm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int AVG_BITS    = SAMPLE_BITS + FRAC_BITS;
    localparam int SUM_BITS    = 48;
    localparam int COUNT_BITS  = 32;
    localparam int CMD_BITS    = 3;
    localparam int STEP_BITS   = 2;
    localparam int AXES        = 3;
    localparam int DVD_BITS    = SUM_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(AVG_BITS);

    localparam logic [STEP_BITS-1:0] STEP_IDLE  = 2'd0;
    localparam logic [STEP_BITS-1:0] STEP_ACCEL = 2'd1;
    localparam logic [STEP_BITS-1:0] STEP_MAG   = 2'd2;
    localparam logic [STEP_BITS-1:0] STEP_GYRO  = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_SAMPLE = 3'd0,
        CMD_START  = 3'd1,
        CMD_RESET  = 3'd2,
        CMD_PAUSE  = 3'd3,
        CMD_NEXT   = 3'd4,
        CMD_FINISH = 3'd5
    } cmd_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic exec;
        logic div_start;
        logic load_out;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;
        logic gyro;
        logic div_done;
        logic out_free;
    } ctl_stat_t;

endpackage

`default_nettype wire

// File: rtl/scsm_if.sv
// Valid/ready channel interfaces for command items and result items.
`default_nettype none

interface scsm_in_if
    import scsm_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic [CMD_BITS-1:0]           cmd;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;

    modport source (output valid, cmd, sample_x, sample_y, sample_z, input ready);
    modport sink   (input valid, cmd, sample_x, sample_y, sample_z, output ready);
endinterface

interface scsm_out_if
    import scsm_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic [STEP_BITS-1:0]          step_shown;
    logic signed [SAMPLE_BITS-1:0] first_x;
    logic signed [SAMPLE_BITS-1:0] first_y;
    logic signed [SAMPLE_BITS-1:0] first_z;
    logic signed [AVG_BITS-1:0]    second_x;
    logic signed [AVG_BITS-1:0]    second_y;
    logic signed [AVG_BITS-1:0]    second_z;
    logic [COUNT_BITS-1:0]         sample_count;

    modport source (output valid, step_shown, first_x, first_y, first_z,
                    second_x, second_y, second_z, sample_count, input ready);
    modport sink   (input valid, step_shown, first_x, first_y, first_z,
                    second_x, second_y, second_z, sample_count, output ready);
endinterface

`default_nettype wire

// File: rtl/scsm_div.sv
// Restoring divider lane: saturated Q.8 average of one gyro axis sum.
`default_nettype none

module scsm_div
    import scsm_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic signed [SUM_BITS-1:0]  sum,
    input  wire logic [COUNT_BITS-1:0]       count,
    output logic                             done,
    output logic signed [AVG_BITS-1:0]       avg
);

    logic [COUNT_BITS-1:0]   rem_reg;
    logic [AVG_BITS-1:0]     quo_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic                    neg_reg;
    logic                    over_reg;
    logic                    zero_reg;

    logic [SUM_BITS-1:0]     mag;
    logic [DVD_BITS-1:0]     dvd;
    logic                    over;
    logic [COUNT_BITS:0]     trial;
    logic [COUNT_BITS:0]     diff;
    logic                    ge;
    logic                    big;

    assign mag   = sum[SUM_BITS-1] ? (~sum) + SUM_BITS'(1) : sum;
    assign dvd   = {mag, FRAC_BITS'(0)};
    assign over  = dvd >= {count, AVG_BITS'(0)};
    assign trial = {rem_reg, quo_reg[AVG_BITS-1]};
    assign diff  = trial - {1'b0, count};
    assign ge    = trial >= {1'b0, count};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(AVG_BITS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // High part of the dividend seeds the remainder; low part shifts out as quotient comes in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dvd[DVD_BITS-1 -: COUNT_BITS];
            quo_reg  <= dvd[AVG_BITS-1:0];
            neg_reg  <= sum[SUM_BITS-1];
            over_reg <= over;
            zero_reg <= (count == '0);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            quo_reg <= {quo_reg[AVG_BITS-2:0], ge};
        end
    end

    assign big  = over_reg || quo_reg[AVG_BITS-1];
    assign done = done_reg;

    always_comb
    begin
        if (zero_reg)
            avg = '0;
        else if (neg_reg)
            avg = big ? {1'b1, {(AVG_BITS-1){1'b0}}} : (~quo_reg) + AVG_BITS'(1);
        else
            avg = big ? {1'b0, {(AVG_BITS-1){1'b1}}} : quo_reg;
    end

endmodule

`default_nettype wire

// File: rtl/scsm_dp.sv
// Datapath: item latch, session state, min/max and gyro sums, divider lanes, result register.
`default_nettype none

module scsm_dp
    import scsm_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ctl_cmd_t                      cmd,
    output ctl_stat_t                          stat,
    input  wire logic [CMD_BITS-1:0]           in_cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] in_x,
    input  wire logic signed [SAMPLE_BITS-1:0] in_y,
    input  wire logic signed [SAMPLE_BITS-1:0] in_z,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [STEP_BITS-1:0]               out_step,
    output logic signed [SAMPLE_BITS-1:0]      out_first [AXES],
    output logic signed [AVG_BITS-1:0]         out_second [AXES],
    output logic [COUNT_BITS-1:0]              out_count
);

    logic [CMD_BITS-1:0]           cmd_reg;
    logic signed [SAMPLE_BITS-1:0] smp_reg [AXES];

    logic [STEP_BITS-1:0]          step_reg;
    logic                          paused_reg;
    logic signed [SAMPLE_BITS-1:0] acc_lo_reg [AXES];
    logic signed [SAMPLE_BITS-1:0] acc_hi_reg [AXES];
    logic signed [SAMPLE_BITS-1:0] mag_lo_reg [AXES];
    logic signed [SAMPLE_BITS-1:0] mag_hi_reg [AXES];
    logic signed [SUM_BITS-1:0]    sum_reg [AXES];
    logic [COUNT_BITS-1:0]         count_reg;

    logic                          out_valid_reg;
    logic [STEP_BITS-1:0]          out_step_reg;
    logic signed [SAMPLE_BITS-1:0] out_first_reg [AXES];
    logic signed [AVG_BITS-1:0]    out_second_reg [AXES];
    logic [COUNT_BITS-1:0]         out_count_reg;

    logic [AXES-1:0]               div_done;
    logic signed [AVG_BITS-1:0]    avg [AXES];
    logic                          sample_go;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            cmd_reg    <= in_cmd;
            smp_reg[0] <= in_x;
            smp_reg[1] <= in_y;
            smp_reg[2] <= in_z;
        end
    end

    assign sample_go = (cmd_reg == CMD_SAMPLE) && (step_reg != STEP_IDLE) && !paused_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_IDLE;
            paused_reg <= 1'b0;
            count_reg  <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                acc_lo_reg[i] <= '0;
                acc_hi_reg[i] <= '0;
                mag_lo_reg[i] <= '0;
                mag_hi_reg[i] <= '0;
                sum_reg[i]    <= '0;
            end
        end
        else if (cmd.exec)
        begin
            if (cmd_reg == CMD_START)
            begin
                step_reg   <= STEP_ACCEL;
                paused_reg <= 1'b0;
            end
            else if (step_reg != STEP_IDLE)
            begin
                case (cmd_reg)
                    CMD_SAMPLE:
                    begin
                        if (!paused_reg)
                        begin
                            for (int i = 0; i < AXES; i++)
                            begin
                                if (step_reg == STEP_ACCEL)
                                begin
                                    if (smp_reg[i] < acc_lo_reg[i]) acc_lo_reg[i] <= smp_reg[i];
                                    if (smp_reg[i] > acc_hi_reg[i]) acc_hi_reg[i] <= smp_reg[i];
                                end
                                else if (step_reg == STEP_MAG)
                                begin
                                    if (smp_reg[i] < mag_lo_reg[i]) mag_lo_reg[i] <= smp_reg[i];
                                    if (smp_reg[i] > mag_hi_reg[i]) mag_hi_reg[i] <= smp_reg[i];
                                end
                                else if (count_reg != COUNT_MAX)
                                begin
                                    sum_reg[i] <= sum_reg[i] + SUM_BITS'(smp_reg[i]);
                                end
                            end
                            // freeze sums and count once the count saturates
                            if ((step_reg == STEP_GYRO) && (count_reg != COUNT_MAX))
                                count_reg <= count_reg + COUNT_BITS'(1);
                        end
                    end
                    CMD_RESET:
                    begin
                        for (int i = 0; i < AXES; i++)
                        begin
                            if (step_reg == STEP_ACCEL)
                            begin
                                acc_lo_reg[i] <= '0;
                                acc_hi_reg[i] <= '0;
                            end
                            else if (step_reg == STEP_MAG)
                            begin
                                mag_lo_reg[i] <= '0;
                                mag_hi_reg[i] <= '0;
                            end
                            else
                            begin
                                sum_reg[i] <= '0;
                            end
                        end
                        if (step_reg == STEP_GYRO)
                            count_reg <= '0;
                    end
                    CMD_PAUSE:
                        paused_reg <= !paused_reg;
                    CMD_NEXT:
                        step_reg <= (step_reg == STEP_GYRO) ? STEP_ACCEL
                                                            : step_reg + STEP_BITS'(1);
                    CMD_FINISH:
                        step_reg <= STEP_IDLE;
                    default:
                        step_reg <= step_reg;
                endcase
            end
        end
    end

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        scsm_div u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (cmd.div_start),
            .sum   (sum_reg[g]),
            .count (count_reg),
            .done  (div_done[g]),
            .avg   (avg[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_step_reg <= step_reg;
            for (int i = 0; i < AXES; i++)
            begin
                if (step_reg == STEP_GYRO)
                begin
                    out_first_reg[i]  <= smp_reg[i];
                    out_second_reg[i] <= avg[i];
                end
                else if (step_reg == STEP_ACCEL)
                begin
                    out_first_reg[i]  <= acc_lo_reg[i];
                    out_second_reg[i] <= AVG_BITS'(acc_hi_reg[i]);
                end
                else
                begin
                    out_first_reg[i]  <= mag_lo_reg[i];
                    out_second_reg[i] <= AVG_BITS'(mag_hi_reg[i]);
                end
            end
            out_count_reg <= (step_reg == STEP_GYRO) ? count_reg : '0;
        end
    end

    assign stat.emit     = sample_go;
    assign stat.gyro     = (step_reg == STEP_GYRO);
    assign stat.div_done = &div_done;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_step   = out_step_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;
    assign out_count  = out_count_reg;

endmodule

`default_nettype wire

// File: rtl/scsm_ctrl.sv
// Controller state machine: sequences take, execute, divide and result load.
`default_nettype none

module scsm_ctrl
    import scsm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire ctl_stat_t stat,
    output ctl_cmd_t       cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_EXEC     = 5'b00010,
        S_DIV_GO   = 5'b00100,
        S_DIV_WAIT = 5'b01000,
        S_LOAD     = 5'b10000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.take      = 1'b0;
        cmd.exec      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take = in_valid;
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (!stat.emit)
                    state_next = S_IDLE;
                else if (stat.gyro)
                    state_next = S_DIV_GO;
                else
                    state_next = S_LOAD;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // hold until the result register drains
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

// File: rtl/sensor_calibration_session_monitor_core.sv
// Top level of the three-axis calibration session monitor.
//
// cmd_chan carries command items (sample, start, reset step, pause, next, finish)
// with a three-axis reading; result_chan carries one result item per sample
// taken while a step runs unpaused. Both channels move an item on valid & ready.
// Sequence: an item is taken when the controller is idle and then executed; a
// command that yields no result returns to idle, an accelerometer or magnetometer
// sample goes on to the load state, and a gyro sample first starts the dividers and
// waits for them. The next item is taken only once the controller is idle again.
// Gyro averages come from three parallel restoring divider lanes, one quotient bit
// per cycle over 24 bits, while the controller waits in its divide state.
// Results sit in an output register: the block takes the next item while a
// result waits, and holds in its load state only when a new result is ready
// and the previous one has not yet been taken.
// Reset clears the session to idle, unpaused, with all min/max, sums and count
// at zero, and drops any pending result.
`default_nettype none

module sensor_calibration_session_monitor_core
    import scsm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    scsm_in_if.sink    cmd_chan,
    scsm_out_if.source result_chan
);

    ctl_cmd_t                      cmd;
    ctl_stat_t                     stat;
    logic signed [SAMPLE_BITS-1:0] first [AXES];
    logic signed [AVG_BITS-1:0]    second [AXES];

    scsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_chan.valid),
        .in_ready (cmd_chan.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scsm_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_cmd     (cmd_chan.cmd),
        .in_x       (cmd_chan.sample_x),
        .in_y       (cmd_chan.sample_y),
        .in_z       (cmd_chan.sample_z),
        .out_ready  (result_chan.ready),
        .out_valid  (result_chan.valid),
        .out_step   (result_chan.step_shown),
        .out_first  (first),
        .out_second (second),
        .out_count  (result_chan.sample_count)
    );

    assign result_chan.first_x  = first[0];
    assign result_chan.first_y  = first[1];
    assign result_chan.first_z  = first[2];
    assign result_chan.second_x = second[0];
    assign result_chan.second_y = second[1];
    assign result_chan.second_z = second[2];

endmodule

`default_nettype wire

// File: rtl/scsm_checker.sv
// Port-level checker for the calibration session monitor, bound to the top level.
`default_nettype none

module scsm_checker
    import scsm_pkg::*;
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [STEP_BITS-1:0]          step_shown,
    input wire logic signed [SAMPLE_BITS-1:0] first_x,
    input wire logic signed [AVG_BITS-1:0]    second_x,
    input wire logic [COUNT_BITS-1:0]         sample_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(step_shown) && $stable(sample_count))
        else $error("result item changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while previous item still in work");

    a_step_nonidle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> step_shown != STEP_IDLE)
        else $error("result item from idle session");

    a_gyro_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (step_shown == STEP_GYRO) == (sample_count != '0))
        else $error("sample count does not match step");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_shown != STEP_GYRO |-> AVG_BITS'(first_x) <= second_x)
        else $error("minimum above maximum");

endmodule

bind sensor_calibration_session_monitor_core scsm_checker u_scsm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (cmd_chan.valid),
    .in_ready     (cmd_chan.ready),
    .out_valid    (result_chan.valid),
    .out_ready    (result_chan.ready),
    .step_shown   (result_chan.step_shown),
    .first_x      (result_chan.first_x),
    .second_x     (result_chan.second_x),
    .sample_count (result_chan.sample_count)
);

`default_nettype wire
